>>> sv/tkv_pkg.sv
package tkv_pkg;

	// storage depth of one value
	localparam int unsigned TKV_VALUE_DEPTH = 64;

	// key register set
	localparam int unsigned KEY_CHARS = 16;
	localparam int unsigned KEY_LEN_W = 5;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LEN = 2'd2;

	// special characters
	localparam logic [7:0] CH_EQUAL = 8'h3d;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef enum logic [2:0] {
		PH_KEY_LEAD   = 3'd0,
		PH_KEY        = 3'd1,
		PH_VALUE_LEAD = 3'd2,
		PH_VALUE      = 3'd3,
		PH_SKIP       = 3'd4,
		PH_DONE       = 3'd5
	} phase_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_SEND = 1'b1
	} back_state_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? c + CASE_OFFSET : c;
	endfunction

endpackage

>>> sv/tkv_job_fifo.sv
module tkv_job_fifo
	import tkv_pkg::*;
#(
	parameter int unsigned WIDTH = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty,
	output logic             full
);

	localparam int unsigned DEPTH = 2;

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign empty = (count_q == 2'd0);
	assign full = (count_q == 2'(DEPTH));
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/tkv_front.sv
module tkv_front
	import tkv_pkg::*;
#(
	parameter int unsigned VALUE_DEPTH = TKV_VALUE_DEPTH,
	parameter int unsigned CNT_W = $clog2(VALUE_DEPTH + 1),
	parameter int unsigned ADDR_W = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  text_valid,
	output logic                  text_ready,
	input  logic [7:0]            text_byte,
	input  logic                  text_end,
	input  logic [63:0]           key_low,
	input  logic [63:0]           key_high,
	input  logic [KEY_LEN_W-1:0]  key_len,
	input  logic                  job_full,
	output logic                  job_push,
	output logic [CNT_W+1:0]      job_data,
	output logic                  mem_we,
	output logic [ADDR_W-1:0]     mem_waddr,
	output logic [7:0]            mem_wdata,
	input  logic                  value_sent,
	output logic                  value_busy
);

	localparam logic [KEY_LEN_W-1:0] POS_MAX = '1;

	phase_t               phase_q, phase_d;
	logic [KEY_LEN_W-1:0] key_pos_q, key_pos_d;
	logic                 key_match_q, key_match_d;
	logic [KEY_LEN_W-1:0] key_tlen_q, key_tlen_d;
	logic                 key_gap_q, key_gap_d;
	logic [CNT_W-1:0]     val_cnt_q, val_cnt_d;
	logic [CNT_W-1:0]     val_tcnt_q, val_tcnt_d;
	logic [CNT_W-1:0]     val_ovf_dummy_unused_never;
	logic                 val_ovf_q, val_ovf_d;
	logic                 busy_q;

	logic                 accept;
	logic                 blank;
	logic                 mis;
	logic                 restart;
	logic [127:0]         key_all;
	logic [7:0]           key_ch;
	logic [KEY_LEN_W-1:0] pos_inc;
	logic [CNT_W-1:0]     job_len;
	logic                 job_trunc;
	logic                 job_found;

	// the store may only be written when no earlier value is still draining
	assign text_ready = !job_full &&
		!(busy_q && (phase_q == PH_VALUE_LEAD || phase_q == PH_VALUE));
	assign accept = text_valid && text_ready;
	assign value_busy = busy_q;

	assign blank = is_blank(text_byte);
	assign key_all = {key_high, key_low};
	assign key_ch = key_all[key_pos_q[3:0]*8 +: 8];
	assign pos_inc = (key_pos_q == POS_MAX) ? POS_MAX : key_pos_q + KEY_LEN_W'(1);
	assign mis = (key_pos_q >= key_len) || key_pos_q[KEY_LEN_W-1] ||
		(to_lower(text_byte) != to_lower(key_ch));

	assign mem_waddr = val_cnt_q[ADDR_W-1:0];
	assign mem_wdata = text_byte;
	assign job_data = {job_len, job_trunc, job_found};

	always_comb begin
		phase_d = phase_q;
		key_pos_d = key_pos_q;
		key_match_d = key_match_q;
		key_tlen_d = key_tlen_q;
		key_gap_d = key_gap_q;
		val_cnt_d = val_cnt_q;
		val_tcnt_d = val_tcnt_q;
		val_ovf_d = val_ovf_q;
		restart = 1'b0;
		mem_we = 1'b0;
		job_push = 1'b0;
		job_len = '0;
		job_trunc = 1'b0;
		job_found = 1'b0;

		if (accept) begin
			case (phase_q)
				PH_KEY_LEAD, PH_KEY: begin
					if (text_byte == CH_NEWLINE) begin
						restart = 1'b1;
					end else if (text_byte == CH_EQUAL) begin
						phase_d = (key_match_q && key_tlen_q == key_len) ?
							PH_VALUE_LEAD : PH_SKIP;
					end else if (!(phase_q == PH_KEY_LEAD && blank)) begin
						phase_d = PH_KEY;
						if (blank) begin
							if (mis) begin
								key_gap_d = 1'b1;
							end
						end else begin
							if (mis || key_gap_q) begin
								key_match_d = 1'b0;
							end
							key_gap_d = 1'b0;
							key_tlen_d = pos_inc;
						end
						key_pos_d = pos_inc;
					end
				end
				PH_VALUE_LEAD, PH_VALUE: begin
					if (text_byte == CH_NEWLINE) begin
						job_push = 1'b1;
						phase_d = PH_DONE;
					end else if (!(phase_q == PH_VALUE_LEAD && blank)) begin
						phase_d = PH_VALUE;
						if (val_cnt_q < CNT_W'(VALUE_DEPTH)) begin
							mem_we = 1'b1;
							val_cnt_d = val_cnt_q + CNT_W'(1);
							if (!blank) begin
								val_tcnt_d = val_cnt_q + CNT_W'(1);
							end
						end else if (!blank) begin
							val_ovf_d = 1'b1;
						end
					end
				end
				PH_SKIP: begin
					if (text_byte == CH_NEWLINE) begin
						restart = 1'b1;
					end
				end
				PH_DONE: begin
				end
				default: begin
					restart = 1'b1;
				end
			endcase

			if (restart) begin
				phase_d = PH_KEY_LEAD;
				key_pos_d = '0;
				key_match_d = 1'b1;
				key_tlen_d = '0;
				key_gap_d = 1'b0;
				val_cnt_d = '0;
				val_tcnt_d = '0;
				val_ovf_d = 1'b0;
			end

			if (text_end && (phase_d == PH_VALUE_LEAD || phase_d == PH_VALUE)) begin
				job_push = 1'b1;
			end

			if (job_push) begin
				job_len = val_ovf_d ? val_cnt_d : val_tcnt_d;
				job_trunc = val_ovf_d;
				job_found = 1'b1;
			end else if (text_end && phase_d != PH_DONE) begin
				job_push = 1'b1;
			end

			if (text_end) begin
				phase_d = PH_KEY_LEAD;
				key_pos_d = '0;
				key_match_d = 1'b1;
				key_tlen_d = '0;
				key_gap_d = 1'b0;
				val_cnt_d = '0;
				val_tcnt_d = '0;
				val_ovf_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY_LEAD;
			key_pos_q <= '0;
			key_match_q <= 1'b1;
			key_tlen_q <= '0;
			key_gap_q <= 1'b0;
			val_cnt_q <= '0;
			val_tcnt_q <= '0;
			val_ovf_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			key_pos_q <= key_pos_d;
			key_match_q <= key_match_d;
			key_tlen_q <= key_tlen_d;
			key_gap_q <= key_gap_d;
			val_cnt_q <= val_cnt_d;
			val_tcnt_q <= val_tcnt_d;
			val_ovf_q <= val_ovf_d;
			if (job_push && job_found) begin
				busy_q <= 1'b1;
			end else if (value_sent) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/tkv_back.sv
module tkv_back
	import tkv_pkg::*;
#(
	parameter int unsigned VALUE_DEPTH = TKV_VALUE_DEPTH,
	parameter int unsigned CNT_W = $clog2(VALUE_DEPTH + 1),
	parameter int unsigned ADDR_W = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mem_we,
	input  logic [ADDR_W-1:0] mem_waddr,
	input  logic [7:0]        mem_wdata,
	input  logic              job_empty,
	input  logic [CNT_W+1:0]  job_head,
	output logic              job_pop,
	output logic              value_sent,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [7:0]        value_byte,
	output logic              byte_valid,
	output logic              found,
	output logic              truncated,
	output logic              final_item
);

	logic [7:0]        mem [VALUE_DEPTH];
	logic [7:0]        rd_q;
	logic [ADDR_W-1:0] raddr;

	back_state_t       state_q, state_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0]  len_q;
	logic              trunc_q;
	logic              found_q;
	logic              beat_done;

	assign final_item = (len_q == '0) || ((CNT_W'(idx_q) + CNT_W'(1)) == len_q);
	assign beat_done = (state_q == BK_SEND) && result_ready;

	// next state and index
	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		case (state_q)
			BK_IDLE: begin
				if (!job_empty) begin
					state_d = BK_SEND;
					idx_d = '0;
				end
			end
			BK_SEND: begin
				if (result_ready) begin
					if (final_item) begin
						state_d = BK_IDLE;
					end else begin
						idx_d = idx_q + ADDR_W'(1);
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		job_pop = 1'b0;
		value_sent = 1'b0;
		result_valid = 1'b0;
		raddr = '0;
		case (state_q)
			BK_IDLE: begin
				job_pop = !job_empty;
			end
			BK_SEND: begin
				result_valid = 1'b1;
				value_sent = beat_done && final_item && found_q;
				raddr = idx_d;
			end
			default: begin
			end
		endcase
	end

	assign byte_valid = (len_q != '0);
	assign value_byte = byte_valid ? rd_q : 8'h00;
	assign found = found_q;
	assign truncated = trunc_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			{len_q, trunc_q, found_q} <= job_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
		end
	end

endmodule

>>> sv/tag_key_value_lookup_top.sv
// parsing: one text beat per cycle while text_ready is high; a lookup result passes
// through the job queue and then the sender state register before it is offered
// value burst: one beat per cycle from the value store while ready, idle state per lookup
// input stalls at a value byte while the previous value is still draining,
// and at any byte while the two-entry job queue is full
// reset: control and key registers cleared, value store left as is (read only once written)
module tag_key_value_lookup_top
	import tkv_pkg::*;
#(
	parameter int unsigned VALUE_DEPTH = TKV_VALUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   text_valid,
	output logic                   text_ready,
	input  logic [7:0]             text_byte,
	input  logic                   text_end,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic [7:0]             value_byte,
	output logic                   byte_valid,
	output logic                   found,
	output logic                   truncated,
	output logic                   final_item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned CNT_W = $clog2(VALUE_DEPTH + 1);
	localparam int unsigned ADDR_W = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;

	// key registers, to be written only while the block is idle; the block does not enforce it
	logic [63:0]          key_low_q;
	logic [63:0]          key_high_q;
	logic [KEY_LEN_W-1:0] key_len_q;

	// job queue between parser and result sender
	logic                 job_push;
	logic [CNT_W+1:0]     job_data;
	logic                 job_pop;
	logic [CNT_W+1:0]     job_head;
	logic                 job_empty;
	logic                 job_full;

	// value store write port, driven by the parser
	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_waddr;
	logic [7:0]           mem_wdata;

	// handoff of the value store back to the parser
	logic                 value_sent;
	logic                 value_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
			key_len_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KEY_LOW: key_low_q <= cfg_data;
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_KEY_LEN: key_len_q <= cfg_data[KEY_LEN_W-1:0];
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	// front: line splitting, key trim and compare, value capture
	tkv_front #(
		.VALUE_DEPTH(VALUE_DEPTH),
		.CNT_W(CNT_W),
		.ADDR_W(ADDR_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text_byte(text_byte),
		.text_end(text_end),
		.key_low(key_low_q),
		.key_high(key_high_q),
		.key_len(key_len_q),
		.job_full(job_full),
		.job_push(job_push),
		.job_data(job_data),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.value_sent(value_sent),
		.value_busy(value_busy)
	);

	// two-entry queue of finished lookups: length, truncated, found
	tkv_job_fifo #(
		.WIDTH(CNT_W + 2)
	) u_job_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.push_data(job_data),
		.pop(job_pop),
		.head(job_head),
		.empty(job_empty),
		.full(job_full)
	);

	// back: value store and result beat sender
	tkv_back #(
		.VALUE_DEPTH(VALUE_DEPTH),
		.CNT_W(CNT_W),
		.ADDR_W(ADDR_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.job_empty(job_empty),
		.job_head(job_head),
		.job_pop(job_pop),
		.value_sent(value_sent),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.value_byte(value_byte),
		.byte_valid(byte_valid),
		.found(found),
		.truncated(truncated),
		.final_item(final_item)
	);

	// the parser never overwrites the store while a value is draining
	assert property (@(posedge clk) disable iff (!arst_n) mem_we |-> !value_busy)
		else $error("value store written while a value is being sent");

	// a not-found result is a single empty, untruncated final beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !found) |-> (final_item && !byte_valid && !truncated))
		else $error("malformed not-found result");

	// the queue never takes a job while full
	assert property (@(posedge clk) disable iff (!arst_n) job_push |-> !job_full)
		else $error("job queue overflow");

endmodule

>>> tb/tag_key_value_lookup_top_test.sv
module tag_key_value_lookup_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tkv_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int RESET_CYCLES = 11;
	localparam int VALUE_DEPTH = TKV_VALUE_DEPTH;
	// cycles with no beat on any channel before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	// quiet margin once the last owed beat is out
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 16;
	localparam int REPORT_MAX = 10;
	localparam int RANDOM_BEATS = 20;
	localparam int GAPLESS_BEATS = 30;

	// one result beat of a lookup
	typedef struct packed {
		logic [7:0] ch;
		logic       has_ch;
		logic       hit;
		logic       cut;
		logic       last;
	} lookup_beat_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   text_valid = 1'b0;
	logic                   text_ready;
	logic [7:0]             text_byte = 8'h00;
	logic                   text_end = 1'b0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	logic [7:0]             value_byte;
	logic                   byte_valid;
	logic                   found;
	logic                   truncated;
	logic                   final_item;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_KEY_LOW;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// key register shadow, same reset values as the block
	logic [63:0] key_lo = '0;
	logic [63:0] key_hi = '0;
	logic [4:0]  key_len = '0;

	// line parser shadow
	phase_t      line_phase;
	logic [4:0]  key_pos;
	logic        key_ok;
	logic [4:0]  key_span;
	logic        gap_miss;
	logic [7:0]  value_mem [VALUE_DEPTH];
	logic [6:0]  value_len;
	logic [6:0]  value_span;
	logic        value_cut;

	// lookup beats still owed by the block, oldest first
	lookup_beat_t lookup_results[$];
	lookup_beat_t beat_seen;
	lookup_beat_t beat_want;

	// key as the stimulus sees it, used to build matching lines
	logic [7:0]  key_text [KEY_CHARS];
	int unsigned key_size = 0;

	logic [7:0]  text_buf[$];
	int unsigned sent_beats = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	bit          send_steady = 1'b0;
	bit          take_steady = 1'b0;

	tag_key_value_lookup_top #(
		.VALUE_DEPTH(VALUE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text_byte(text_byte),
		.text_end(text_end),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.value_byte(value_byte),
		.byte_valid(byte_valid),
		.found(found),
		.truncated(truncated),
		.final_item(final_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------
	// lookup prediction
	// ---------------------------------------------------------------

	// space, tab and carriage return count as blanks
	function automatic logic blank_char(input logic [7:0] c);
		case (c)
			CH_SPACE, CH_TAB, CH_CR: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// folds ascii upper case only
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_OFFSET) : c;
	endfunction

	function automatic logic [7:0] key_char_at(input logic [4:0] p);
		if (p < 8)
			return key_lo[8 * p +: 8];
		if (p < KEY_CHARS)
			return key_hi[8 * (p - 8) +: 8];
		return 8'h00;
	endfunction

	function automatic lookup_beat_t make_beat(input logic [7:0] ch, input logic has_ch,
			input logic hit, input logic cut, input logic last);
		lookup_beat_t b;
		b.ch = ch;
		b.has_ch = has_ch;
		b.hit = hit;
		b.cut = cut;
		b.last = last;
		return b;
	endfunction

	// appends one owed beat at the tail
	function automatic void owe_beat(input lookup_beat_t b);
		lookup_results.insert(lookup_results.size(), b);
	endfunction

	function automatic void restart_line();
		line_phase = PH_KEY_LEAD;
		key_pos = '0;
		key_ok = 1'b1;
		key_span = '0;
		gap_miss = 1'b0;
		value_len = '0;
		value_span = '0;
		value_cut = 1'b0;
	endfunction

	// a cut value goes out untrimmed as stored, otherwise trimmed of its blank tail
	function automatic void queue_value();
		int unsigned n;
		int unsigned i;
		n = value_cut ? value_len : value_span;
		if (n > VALUE_DEPTH)
			n = VALUE_DEPTH;
		if (n == 0)
			owe_beat(make_beat(8'h00, 1'b0, 1'b1, value_cut, 1'b1));
		for (i = 0; i < n; i++)
			owe_beat(make_beat(value_mem[i], 1'b1, 1'b1, value_cut, i + 1 == n));
	endfunction

	// advances the parser by one text beat and queues the lookup beats it causes
	function automatic void parse_tag_byte(input logic [7:0] c, input logic last);
		logic [4:0] p;
		logic       miss;
		if (line_phase == PH_KEY_LEAD || line_phase == PH_KEY) begin
			if (c == CH_NEWLINE) begin
				restart_line();
			end else if (c == CH_EQUAL) begin
				line_phase = (key_ok && key_span == key_len) ? PH_VALUE_LEAD : PH_SKIP;
			end else if (!(line_phase == PH_KEY_LEAD && blank_char(c))) begin
				p = key_pos;
				miss = (p >= key_len) || (p >= KEY_CHARS) ||
					(fold_case(c) != fold_case(key_char_at(p)));
				line_phase = PH_KEY;
				if (blank_char(c)) begin
					// a blank only hurts if something non-blank follows it
					if (miss)
						gap_miss = 1'b1;
				end else begin
					if (miss || gap_miss)
						key_ok = 1'b0;
					gap_miss = 1'b0;
					key_span = (p < 31) ? p + 5'd1 : 5'd31;
				end
				key_pos = (p < 31) ? p + 5'd1 : 5'd31;
			end
		end else if (line_phase == PH_VALUE_LEAD || line_phase == PH_VALUE) begin
			if (c == CH_NEWLINE) begin
				queue_value();
				line_phase = PH_DONE;
			end else if (!(line_phase == PH_VALUE_LEAD && blank_char(c))) begin
				line_phase = PH_VALUE;
				if (value_len < VALUE_DEPTH) begin
					value_mem[value_len] = c;
					value_len = value_len + 7'd1;
					if (!blank_char(c))
						value_span = value_len;
				end else if (!blank_char(c)) begin
					value_cut = 1'b1;
				end
			end
		end else if (line_phase == PH_SKIP) begin
			if (c == CH_NEWLINE)
				restart_line();
		end else if (line_phase != PH_DONE) begin
			restart_line();
		end

		if (last) begin
			if (line_phase == PH_VALUE_LEAD || line_phase == PH_VALUE)
				queue_value();
			else if (line_phase != PH_DONE)
				owe_beat(make_beat(8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
			restart_line();
		end
	endfunction

	// ---------------------------------------------------------------
	// result side: ready with random stalls unless held steady, every beat checked in order
	// ---------------------------------------------------------------

	function automatic bit gap_now(input bit steady);
		return !steady && ($urandom_range(99) < 30);
	endfunction

	function automatic string beat_text(input lookup_beat_t b);
		return $sformatf("byte %02h valid %0b found %0b trunc %0b final %0b",
			b.ch, b.has_ch, b.hit, b.cut, b.last);
	endfunction

	function automatic void note_fault(input string what);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%s", what);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				beat_seen = make_beat(value_byte, byte_valid, found, truncated, final_item);
				if (lookup_results.size() == 0) begin
					note_fault({"value beat with nothing pending: ", beat_text(beat_seen)});
				end else begin
					beat_want = lookup_results.pop_front();
					if (beat_seen.ch !== beat_want.ch || beat_seen.has_ch !== beat_want.has_ch ||
							beat_seen.hit !== beat_want.hit || beat_seen.cut !== beat_want.cut ||
							beat_seen.last !== beat_want.last)
						note_fault({"value beat mismatch, expected ", beat_text(beat_want),
							", got ", beat_text(beat_seen)});
				end
			end
			result_ready <= !gap_now(take_steady);
		end
	end

	// hang detection: any beat on any channel restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_valid && text_ready) || (result_valid && result_ready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ---------------------------------------------------------------
	// text and key drivers
	// ---------------------------------------------------------------

	// valid stays up after the beat so back-to-back texts need no extra edge
	task automatic send_text_beat(input logic [7:0] c, input logic last);
		while (gap_now(send_steady)) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= c;
		text_end <= last;
		@(posedge clk);
		while (!text_ready)
			@(posedge clk);
		parse_tag_byte(c, last);
		sent_beats++;
	endtask

	// sends the assembled text, end flag on its final byte
	task automatic send_text();
		logic [7:0] chars[$];
		chars = text_buf;
		text_buf.delete();
		foreach (chars[i])
			send_text_beat(chars[i], i == chars.size() - 1);
	endtask

	// sender holds off until every owed beat is out and the block is quiet
	task automatic wait_lookup_drained();
		text_valid <= 1'b0;
		while (lookup_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_key_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_KEY_LOW: key_lo = data;
			CFG_KEY_HIGH: key_hi = data;
			CFG_KEY_LEN: key_len = data[KEY_LEN_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// writes key_text and the given length; unused characters keep their filler
	task automatic load_key(input int unsigned len);
		logic [63:0] lo;
		logic [63:0] hi;
		for (int i = 0; i < 8; i++) begin
			lo[8 * i +: 8] = key_text[i];
			hi[8 * i +: 8] = key_text[i + 8];
		end
		wait_lookup_drained();
		key_size = len;
		write_key_reg(CFG_KEY_LOW, lo);
		write_key_reg(CFG_KEY_HIGH, hi);
		write_key_reg(CFG_KEY_LEN, CFG_DATA_W'(len));
	endtask

	task automatic use_key(input string s);
		for (int i = 0; i < KEY_CHARS; i++)
			key_text[i] = (i < s.len()) ? s[i] : 8'($urandom_range(255));
		load_key(s.len());
	endtask

	// appends one character to the text being built
	function automatic void put_char(input logic [7:0] c);
		text_buf.insert(text_buf.size(), c);
	endfunction

	function automatic void push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endfunction

	function automatic logic [7:0] any_letter();
		logic [7:0] c;
		c = CH_UPPER_A + 8'($urandom_range(25));
		if ($urandom_range(1))
			c = c | CASE_OFFSET;
		return c;
	endfunction

	function automatic logic [7:0] any_blank();
		case ($urandom_range(2))
			0: return CH_SPACE;
			1: return CH_TAB;
			default: return CH_CR;
		endcase
	endfunction

	function automatic void push_blanks(input int unsigned most);
		repeat ($urandom_range(most))
			put_char(any_blank());
	endfunction

	// the configured key with letters in random case
	function automatic void push_key_text();
		logic [7:0] c;
		for (int i = 0; i < key_size; i++) begin
			c = key_text[i];
			if (fold_case(c) != fold_case(c ^ CASE_OFFSET) || !(fold_case(c) >= 8'h61 &&
					fold_case(c) <= 8'h7a))
				c = c;
			else if ($urandom_range(1))
				c = c ^ CASE_OFFSET;
			put_char(c);
		end
	endfunction

	// value of random bytes, mostly short, now and then near or past the store depth
	function automatic void push_value();
		int unsigned n;
		logic [7:0]  c;
		n = ($urandom_range(14) == 0) ? $urandom_range(VALUE_DEPTH + 6, VALUE_DEPTH - 4)
			: $urandom_range(6);
		push_blanks(2);
		repeat (n) begin
			c = 8'($urandom_range(255));
			if (c == CH_NEWLINE)
				c = CH_EQUAL;
			put_char(c);
		end
		push_blanks(2);
	endfunction

	// a few lines: mostly well formed, some with other keys, some noise
	function automatic void build_random_text();
		int unsigned lines;
		int unsigned kind;
		lines = $urandom_range(4, 1);
		for (int l = 0; l < lines; l++) begin
			kind = $urandom_range(99);
			if (kind < 40) begin
				push_blanks(2);
				push_key_text();
				push_blanks(2);
				put_char(CH_EQUAL);
				push_value();
			end else if (kind < 65) begin
				repeat ($urandom_range(5, 1))
					put_char(any_letter());
				put_char(CH_EQUAL);
				push_value();
			end else if (kind < 80) begin
				repeat ($urandom_range(8, 1))
					put_char(any_letter());
			end else begin
				repeat ($urandom_range(6, 1))
					put_char(8'($urandom_range(255)));
			end
			if (l != lines - 1 || $urandom_range(1))
				put_char(CH_NEWLINE);
		end
	endfunction

	task automatic load_random_key();
		int unsigned len;
		case ($urandom_range(9))
			0: len = 0;
			1: len = KEY_CHARS;
			default: len = $urandom_range(8, 1);
		endcase
		for (int i = 0; i < KEY_CHARS; i++) begin
			if (i >= len)
				key_text[i] = 8'($urandom_range(255));
			else begin
				case ($urandom_range(5))
					0: key_text[i] = 8'h30 + 8'($urandom_range(9));
					1: key_text[i] = 8'h80 + 8'($urandom_range(127));
					default: key_text[i] = any_letter();
				endcase
			end
		end
		load_key(len);
	endtask

	task automatic run_random_texts(input int unsigned beats);
		int unsigned start;
		start = sent_beats;
		while (sent_beats - start < beats) begin
			if ($urandom_range(3) == 0)
				load_random_key();
			build_random_text();
			send_text();
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset key is empty: a blank-only key line matches
	task automatic test_empty_key();
		push_str("a=1\n \t= v \n");
		send_text();
		push_str("=");
		send_text();
		use_key("");
		push_str("x=\n");
		send_text();
	endtask

	// case folding, blank trimming, '=' inside a value, rest of text ignored
	task automatic test_case_blind_match();
		use_key("Title");
		push_str("artist=Foo\n  tItLe \t= \tHello = World \r\nTITLE=second\n");
		send_text();
	endtask

	// lines without '=', longer keys, keys broken by blanks, empty value
	task automatic test_skipped_lines();
		use_key("ab");
		push_str("ab\nab x=1\nabc=2\na b=3\n=4\nAB=");
		send_text();
		use_key("my key");
		push_str("my  key=no\nMY KEY = yes");
		send_text();
	endtask

	// value closed by the end of text, and texts with no match at all
	task automatic test_not_found_and_cut_text();
		use_key("k");
		push_str("x=1\nk=abc");
		send_text();
		push_str("nothing here");
		send_text();
		push_str("\n");
		send_text();
	endtask

	// key length past the key registers never matches
	task automatic test_oversized_key_length();
		use_key("abc");
		write_key_reg(CFG_KEY_LEN, CFG_DATA_W'(KEY_CHARS + 1));
		push_str("abc=1\n=2");
		send_text();
		wait_lookup_drained();
		write_key_reg(CFG_KEY_LEN, CFG_DATA_W'(31));
		push_str("=3");
		send_text();
	endtask

	// sixteen character keys with extreme byte values
	task automatic test_full_width_key();
		for (int i = 0; i < KEY_CHARS; i++)
			key_text[i] = 8'hff;
		load_key(KEY_CHARS);
		push_key_text();
		push_str("=z");
		send_text();

		for (int i = 0; i < KEY_CHARS; i++)
			key_text[i] = 8'h61 + 8'(i);
		key_text[0] = 8'hff;
		key_text[1] = 8'h00;
		key_text[2] = 8'h51;
		key_text[3] = 8'h80;
		key_text[15] = 8'h7f;
		load_key(KEY_CHARS);
		// one character too many
		push_key_text();
		push_str("x=no\n");
		push_key_text();
		push_str(" = ");
		put_char(8'hff);
		put_char(8'h00);
		put_char(8'h7f);
		put_char(8'h80);
		send_text();
	endtask

	// values longer than the store: blank tail dropped quietly, or cut with flag
	// where the stored part keeps its inner blanks
	task automatic test_value_overflow();
		use_key("v");
		push_str("v= ");
		repeat (VALUE_DEPTH - 2)
			put_char(8'h61);
		push_str(" \t\r");
		send_text();

		push_str("v=");
		repeat (VALUE_DEPTH - 4)
			put_char(8'h62);
		push_str("     c");
		send_text();
	endtask

	task automatic test_random_lookups();
		run_random_texts(RANDOM_BEATS);
	endtask

	// both sides without any idle cycle
	task automatic test_gapless_stream();
		send_steady = 1'b1;
		take_steady = 1'b1;
		run_random_texts(GAPLESS_BEATS);
		wait_lookup_drained();
		send_steady = 1'b0;
		take_steady = 1'b0;
	endtask

	initial begin
		restart_line();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_key();
		test_case_blind_match();
		test_skipped_lines();
		test_not_found_and_cut_text();
		test_oversized_key_length();
		test_full_width_key();
		test_value_overflow();
		test_random_lookups();
		test_gapless_stream();

		wait_lookup_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && lookup_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> files.f
sv/tkv_pkg.sv
sv/tkv_job_fifo.sv
sv/tkv_front.sv
sv/tkv_back.sv
sv/tag_key_value_lookup_top.sv
tb/tag_key_value_lookup_top_test.sv
